### rtl/core/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// shared widths, codes and helpers of the vertex normal accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package vna_pkg;

	localparam int VTX_DEPTH   = 4096;
	localparam int VTX_AW      = $clog2(VTX_DEPTH);
	localparam int IDX_W       = 12;
	localparam int ACT_W       = 2;
	localparam int POS_W       = 16;
	localparam int SUM_W       = 24;
	localparam int OUT_W       = 24;
	localparam int POSREC_W    = 3 * POS_W;
	localparam int SUMREC_W    = 3 * SUM_W;
	localparam int D_W         = POS_W + 1;
	localparam int MUL_W       = 19;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int VEC_W       = 36;
	localparam int MAG_W       = VEC_W - 1;
	localparam int MAG_LO_W    = 18;
	localparam int MAG_HI_W    = MAG_W - MAG_LO_W;
	localparam int SQ_W        = 72;
	localparam int LEN_W       = 37;
	localparam int UNIT_SHIFT  = 14;
	localparam int Q_W         = UNIT_SHIFT + 1;
	localparam int U_W         = Q_W + 1;
	localparam int DIVD_W      = MAG_W + UNIT_SHIFT;
	localparam int DIV_REM_W   = LEN_W + UNIT_SHIFT;
	localparam int STEP_W      = 4;

	localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_TRI  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

	localparam logic [Q_W-1:0] Q_MAX = Q_W'(1 << UNIT_SHIFT);

	localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'((1 << (SUM_W-1)) - 1);
	localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W+1)'(1 << (SUM_W-1));

	function automatic logic [VTX_AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
		logic [31:0] w;
		w = 32'(idx);
		return w[VTX_AW-1:0];
	endfunction

	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		return 32'(idx) < 32'(VTX_DEPTH);
	endfunction

endpackage

`default_nettype wire

### rtl/core/vna_if.sv
// ----------------------------------------------------------------------------
// vna channel interfaces
// valid/ready channels for items, results and the register write
// ----------------------------------------------------------------------------
`default_nettype none

interface vna_item_if import vna_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [ACT_W-1:0]        action;
	logic [IDX_W-1:0]        index_a;
	logic [IDX_W-1:0]        index_b;
	logic [IDX_W-1:0]        index_c;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	modport source (output valid, action, index_a, index_b, index_c, pos_x, pos_y, pos_z,
		input ready);
	modport sink (input valid, action, index_a, index_b, index_c, pos_x, pos_y, pos_z,
		output ready);
endinterface

interface vna_result_if import vna_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] normal_x;
	logic signed [OUT_W-1:0] normal_y;
	logic signed [OUT_W-1:0] normal_z;
	modport source (output valid, normal_x, normal_y, normal_z, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

interface vna_cfg_if;
	logic valid;
	logic ready;
	logic normalize_readout;
	modport source (output valid, normalize_readout, input ready);
	modport sink (input valid, normalize_readout, output ready);
endinterface

`default_nettype wire

### rtl/core/vertex_normal_accumulator_unit.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_unit
// per-vertex face normal accumulation with unit scaling
// ----------------------------------------------------------------------------
// item channel: load a position, add a triangle or read a normal sum.
// result channel: one transfer per read item, nothing for other actions.
// cfg channel: always ready, sets normalize_readout; write it while idle.
// item.ready is high only while the sequencer is idle.
// load: ready again the next cycle. raw read: the sum is read in S_RDS and
// S_RDW and goes to the output register from S_OUT.
// triangle: one shared 19x19 multiplier (6 cross products, 9 partial
// squares), a 37-step square root and three 15-step divisions (none for a
// zero face normal), then three sum read-modify-writes.
// normalized read: the sum goes through the same units, with no division
// for a zero sum, before the result is registered.
// reset: sums are cleared by a pass over all 4096 entries, one entry per cycle,
// with item.ready low; positions read as unknown until loaded.
// a stalled result holds in the output register; the next item is
// still taken, and a following read waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_normal_accumulator_unit import vna_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	vna_item_if.sink  item,
	vna_result_if.source result,
	vna_cfg_if.sink   cfg
);

	typedef enum logic [15:0] {
		S_CLR   = 16'h0001,
		S_IDLE  = 16'h0002,
		S_P0    = 16'h0004,
		S_P1    = 16'h0008,
		S_P2    = 16'h0010,
		S_P3    = 16'h0020,
		S_CROSS = 16'h0040,
		S_MAG   = 16'h0080,
		S_SQ    = 16'h0100,
		S_ROOT  = 16'h0200,
		S_DIV   = 16'h0400,
		S_SR    = 16'h0800,
		S_SW    = 16'h1000,
		S_RDS   = 16'h2000,
		S_RDW   = 16'h4000,
		S_OUT   = 16'h8000
	} state_t;

	state_t state_q;

	logic [VTX_AW-1:0]       clr_q;
	logic [STEP_W-1:0]       st_q;
	logic [1:0]              j_q;
	logic [1:0]              k_q;
	logic                    norm_q;
	logic                    out_vld_q;

	logic [ACT_W-1:0]        act_q;
	logic [IDX_W-1:0]        ia_q, ib_q, ic_q;
	logic signed [POS_W-1:0] u_pos_q [3];
	logic signed [D_W-1:0]   d1_q [3];
	logic signed [D_W-1:0]   d2_q [3];
	logic signed [PROD_W-1:0] acc_q;
	logic signed [VEC_W-1:0] vec_q [3];
	logic [MAG_W-1:0]        mag_q [3];
	logic [SQ_W-1:0]         sq_acc_q;
	logic [5:0]              sh_q;
	logic [LEN_W-1:0]        len_q;
	logic signed [U_W-1:0]   u_q [3];
	logic signed [OUT_W-1:0] out_q [3];

	logic                    item_fire;
	logic                    slot_free;
	logic                    pos_we;
	logic [VTX_AW-1:0]       pos_raddr;
	logic [POSREC_W-1:0]     pos_rdata;
	logic [IDX_W-1:0]        corner_idx;
	logic                    sum_we;
	logic [VTX_AW-1:0]       sum_waddr;
	logic [SUMREC_W-1:0]     sum_wdata;
	logic [VTX_AW-1:0]       sum_raddr;
	logic [SUMREC_W-1:0]     sum_rdata;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic [5:0]              mul_sh;
	logic                    sq_start, sq_busy, sq_done;
	logic [LEN_W-1:0]        sq_root;
	logic                    div_start, div_done;
	logic [1:0]              div_j;
	logic [DIVD_W-1:0]       div_dividend;
	logic [LEN_W-1:0]        div_divisor;
	logic [Q_W-1:0]          div_quo;
	logic [1:0]              cj;

	assign item_fire  = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign slot_free  = !out_vld_q || result.ready;
	assign cj         = st_q[2:1] - 2'd1;

	// position store
	assign pos_we = item_fire && (item.action == ACT_LOAD) && in_range(item.index_a);

	always_comb begin
		unique case (state_q)
			S_P1:    pos_raddr = to_addr(ib_q);
			S_P2:    pos_raddr = to_addr(ic_q);
			default: pos_raddr = to_addr(ia_q);
		endcase
	end

	vna_ram #(.WIDTH(POSREC_W), .DEPTH(VTX_DEPTH)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (to_addr(item.index_a)),
		.wdata ({item.pos_z, item.pos_y, item.pos_x}),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	// normal sum store
	always_comb begin
		unique case (k_q)
			2'd0:    corner_idx = ia_q;
			2'd1:    corner_idx = ib_q;
			default: corner_idx = ic_q;
		endcase
	end

	always_comb begin
		logic signed [SUM_W:0] s;
		sum_wdata = '0;
		for (int j = 0; j < 3; j++) begin
			s = (SUM_W+1)'($signed(sum_rdata[j*SUM_W +: SUM_W])) + (SUM_W+1)'(u_q[j]);
			if (s > SUM_MAX) begin
				s = SUM_MAX;
			end else if (s < SUM_MIN) begin
				s = SUM_MIN;
			end
			sum_wdata[j*SUM_W +: SUM_W] = s[SUM_W-1:0];
		end
		if (state_q == S_CLR) begin
			sum_wdata = '0;
		end
	end

	assign sum_we    = (state_q == S_CLR) || (state_q == S_SW);
	assign sum_waddr = (state_q == S_CLR) ? clr_q : to_addr(corner_idx);
	assign sum_raddr = (state_q == S_SR) ? to_addr(corner_idx) : to_addr(ia_q);

	vna_ram #(.WIDTH(SUMREC_W), .DEPTH(VTX_DEPTH)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	// shared multiplier operand select
	always_comb begin
		logic [MAG_LO_W-1:0] lo;
		logic [MAG_HI_W-1:0] hi;
		mul_a  = '0;
		mul_b  = '0;
		mul_sh = '0;
		lo     = '0;
		hi     = '0;
		if (state_q == S_CROSS) begin
			unique case (st_q)
				4'd0:    begin mul_a = MUL_W'(d1_q[1]); mul_b = MUL_W'(d2_q[2]); end
				4'd1:    begin mul_a = MUL_W'(d1_q[2]); mul_b = MUL_W'(d2_q[1]); end
				4'd2:    begin mul_a = MUL_W'(d1_q[2]); mul_b = MUL_W'(d2_q[0]); end
				4'd3:    begin mul_a = MUL_W'(d1_q[0]); mul_b = MUL_W'(d2_q[2]); end
				4'd4:    begin mul_a = MUL_W'(d1_q[0]); mul_b = MUL_W'(d2_q[1]); end
				4'd5:    begin mul_a = MUL_W'(d1_q[1]); mul_b = MUL_W'(d2_q[0]); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else if (state_q == S_SQ) begin
			unique case (st_q)
				4'd0, 4'd1, 4'd2: begin
					lo = mag_q[0][MAG_LO_W-1:0];
					hi = mag_q[0][MAG_W-1:MAG_LO_W];
				end
				4'd3, 4'd4, 4'd5: begin
					lo = mag_q[1][MAG_LO_W-1:0];
					hi = mag_q[1][MAG_W-1:MAG_LO_W];
				end
				default: begin
					lo = mag_q[2][MAG_LO_W-1:0];
					hi = mag_q[2][MAG_W-1:MAG_LO_W];
				end
			endcase
			unique case (st_q)
				4'd0, 4'd3, 4'd6: begin
					mul_a = MUL_W'(lo); mul_b = MUL_W'(lo); mul_sh = 6'd0;
				end
				4'd1, 4'd4, 4'd7: begin
					mul_a = MUL_W'(lo); mul_b = MUL_W'(hi); mul_sh = 6'(MAG_LO_W + 1);
				end
				4'd2, 4'd5, 4'd8: begin
					mul_a = MUL_W'(hi); mul_b = MUL_W'(hi); mul_sh = 6'(2 * MAG_LO_W);
				end
				default: begin
					mul_a = '0; mul_b = '0; mul_sh = '0;
				end
			endcase
		end
	end

	vna_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// start once the last partial square has been added
	assign sq_start = (state_q == S_SQ) && (st_q == STEP_W'(10));

	vna_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (sq_acc_q),
		.busy   (sq_busy),
		.done   (sq_done),
		.root   (sq_root)
	);

	assign div_start = ((state_q == S_ROOT) && sq_done && (sq_root != '0)) ||
		((state_q == S_DIV) && div_done && (j_q != 2'd2));
	assign div_j        = (state_q == S_ROOT) ? 2'd0 : j_q + 2'd1;
	assign div_dividend = {mag_q[div_j], UNIT_SHIFT'(0)};
	assign div_divisor  = (state_q == S_ROOT) ? sq_root : len_q;

	vna_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quo      (div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			st_q      <= '0;
			j_q       <= '0;
			k_q       <= '0;
			norm_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				norm_q <= cfg.normalize_readout;
			end
			if (state_q == S_OUT && slot_free) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == VTX_AW'(VTX_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_fire) begin
						unique case (item.action)
							ACT_TRI: begin
								if (in_range(item.index_a) && in_range(item.index_b) &&
									in_range(item.index_c)) begin
									state_q <= S_P0;
								end
							end
							ACT_READ: state_q <= S_RDS;
							ACT_LOAD, ACT_NONE: state_q <= S_IDLE;
						endcase
					end
				end
				S_P0: state_q <= S_P1;
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: begin
					st_q    <= '0;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					st_q <= st_q + 1'b1;
					if (st_q == STEP_W'(6)) begin
						st_q    <= '0;
						state_q <= S_MAG;
					end
				end
				S_MAG: begin
					st_q    <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					st_q <= st_q + 1'b1;
					if (st_q == STEP_W'(10)) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (sq_done) begin
						j_q <= '0;
						k_q <= '0;
						if (sq_root != '0) begin
							state_q <= S_DIV;
						end else begin
							state_q <= (act_q == ACT_TRI) ? S_SR : S_OUT;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						j_q <= j_q + 2'd1;
						if (j_q == 2'd2) begin
							state_q <= (act_q == ACT_TRI) ? S_SR : S_OUT;
						end
					end
				end
				S_SR: state_q <= S_SW;
				S_SW: begin
					k_q <= k_q + 2'd1;
					state_q <= (k_q == 2'd2) ? S_IDLE : S_SR;
				end
				S_RDS: state_q <= S_RDW;
				S_RDW: state_q <= norm_q ? S_MAG : S_OUT;
				S_OUT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item_fire) begin
					act_q <= item.action;
					ia_q  <= item.index_a;
					ib_q  <= item.index_b;
					ic_q  <= item.index_c;
				end
			end
			S_P1: begin
				for (int j = 0; j < 3; j++) begin
					u_pos_q[j] <= $signed(pos_rdata[j*POS_W +: POS_W]);
				end
			end
			S_P2: begin
				for (int j = 0; j < 3; j++) begin
					d1_q[j] <= D_W'($signed(pos_rdata[j*POS_W +: POS_W])) - D_W'(u_pos_q[j]);
				end
			end
			S_P3: begin
				for (int j = 0; j < 3; j++) begin
					d2_q[j] <= D_W'($signed(pos_rdata[j*POS_W +: POS_W])) - D_W'(u_pos_q[j]);
				end
			end
			S_CROSS: begin
				if (st_q != '0) begin
					if (st_q[0]) begin
						acc_q <= mul_p;
					end else begin
						vec_q[cj] <= VEC_W'(acc_q - mul_p);
					end
				end
			end
			S_MAG: begin
				for (int j = 0; j < 3; j++) begin
					mag_q[j] <= vec_q[j][VEC_W-1] ? MAG_W'(-vec_q[j]) : MAG_W'(vec_q[j]);
				end
				sq_acc_q <= '0;
			end
			S_SQ: begin
				sh_q <= mul_sh;
				if (st_q != '0) begin
					sq_acc_q <= sq_acc_q + (SQ_W'(mul_p[PROD_W-3:0]) << sh_q);
				end
			end
			S_ROOT: begin
				if (sq_done) begin
					len_q <= sq_root;
					for (int j = 0; j < 3; j++) begin
						u_q[j] <= '0;
					end
				end
			end
			S_DIV: begin
				if (div_done) begin
					u_q[j_q] <= vec_q[j_q][VEC_W-1] ? -$signed({1'b0, div_quo}) :
						$signed({1'b0, div_quo});
				end
			end
			S_RDW: begin
				for (int j = 0; j < 3; j++) begin
					vec_q[j] <= in_range(ia_q) ?
						VEC_W'($signed(sum_rdata[j*SUM_W +: SUM_W])) : '0;
				end
			end
			S_OUT: begin
				if (slot_free) begin
					for (int j = 0; j < 3; j++) begin
						out_q[j] <= norm_q ? {{(OUT_W-U_W){u_q[j][U_W-1]}}, u_q[j]} :
							vec_q[j][OUT_W-1:0];
					end
				end
			end
			S_CLR, S_P0, S_SR, S_SW, S_RDS: begin
			end
		endcase
	end

	assign result.valid    = out_vld_q;
	assign result.normal_x = out_q[0];
	assign result.normal_y = out_q[1];
	assign result.normal_z = out_q[2];

`ifndef SYNTHESIS
	a_sqrt_free: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> !sq_busy)
		else $error("square root started while busy");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> div_quo <= Q_MAX)
		else $error("unit quotient out of range");

	a_clear_full: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q == S_CLR) |-> $past(clr_q) == VTX_AW'(VTX_DEPTH - 1))
		else $error("clearing pass ended early");
`endif

endmodule

`default_nettype wire

### rtl/core/vna_ram.sv
// ----------------------------------------------------------------------------
// vna_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module vna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/vna_mul.sv
// ----------------------------------------------------------------------------
// vna_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module vna_mul import vna_pkg::*; (
	input  wire logic                     clk,
	input  wire logic signed [MUL_W-1:0]  a,
	input  wire logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0]      p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

`default_nettype wire

### rtl/core/vna_sqrt.sv
// ----------------------------------------------------------------------------
// vna_sqrt
// iterative integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module vna_sqrt import vna_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [SQ_W-1:0] rad,
	output logic                 busy,
	output logic                 done,
	output logic [LEN_W-1:0]     root
);

	localparam int X_W   = 2 * LEN_W;
	localparam int REM_W = LEN_W + 3;
	localparam int CNT_W = $clog2(LEN_W);

	logic [X_W-1:0]   x_q;
	logic [REM_W-1:0] rem_q;
	logic [LEN_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             ge;

	assign rem_sh = {rem_q[LEN_W:0], x_q[X_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(LEN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= X_W'(rad);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[X_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[LEN_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

### rtl/core/vna_div.sv
// ----------------------------------------------------------------------------
// vna_div
// iterative restoring divider for the unit scaling quotient
// ----------------------------------------------------------------------------
`default_nettype none

module vna_div import vna_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVD_W-1:0] dividend,
	input  wire logic [LEN_W-1:0]  divisor,
	output logic                   done,
	output logic [Q_W-1:0]         quo
);

	localparam int CNT_W = $clog2(Q_W);

	logic [DIV_REM_W-1:0] rem_q;
	logic [DIV_REM_W-1:0] dsh_q;
	logic [Q_W-1:0]       quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIV_REM_W'(dividend);
			dsh_q <= {divisor, UNIT_SHIFT'(0)};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_q - dsh_q : rem_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// vertex normal accumulator testbench
// drives loads, triangles and reads through the item channel, predicts each
// read result from a local copy of positions and normal sums, and checks the
// result channel field by field under random idling and long receiver stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class normal_sum_scoreboard;
	logic signed [23:0] exp_x[$];
	logic signed [23:0] exp_y[$];
	logic signed [23:0] exp_z[$];
	int errors;

	function void note_read(logic signed [23:0] x, logic signed [23:0] y,
		logic signed [23:0] z);
		exp_x = {exp_x, x};
		exp_y = {exp_y, y};
		exp_z = {exp_z, z};
	endfunction

	function void check_result(logic signed [23:0] x, logic signed [23:0] y,
		logic signed [23:0] z);
		logic signed [23:0] ex, ey, ez;
		if (exp_x.size() == 0) begin
			$error("unexpected result transfer x=%0d y=%0d z=%0d", x, y, z);
			errors++;
			return;
		end
		ex = exp_x.pop_front();
		ey = exp_y.pop_front();
		ez = exp_z.pop_front();
		if (x !== ex) begin
			$error("normal_x expected %0d actual %0d", ex, x);
			errors++;
		end
		if (y !== ey) begin
			$error("normal_y expected %0d actual %0d", ey, y);
			errors++;
		end
		if (z !== ez) begin
			$error("normal_z expected %0d actual %0d", ez, z);
			errors++;
		end
	endfunction

	function int pending();
		return exp_x.size();
	endfunction
endclass

module tb;
	import vna_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	longint cycles = 0;

	vna_item_if item();
	vna_result_if result();
	vna_cfg_if cfg();

	vertex_normal_accumulator_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	normal_sum_scoreboard sb;

	logic signed [15:0] pos_mem[VTX_DEPTH][3];
	logic signed [23:0] sum_mem[VTX_DEPTH][3];
	bit loaded[VTX_DEPTH];
	int loaded_list[$];
	bit norm_mode = 1'b0;
	bit rx_idle_on = 1'b1;
	bit tx_idle_on = 1'b1;
	bit hold_rx = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd3000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [36:0] isqrt(logic [71:0] sq);
		logic [36:0] r, t;
		r = '0;
		for (int b = 36; b >= 0; b--) begin
			t = r | (37'd1 << b);
			if ({35'd0, t} * {35'd0, t} <= {2'd0, sq})
				r = t;
		end
		return r;
	endfunction

	function automatic void unit_vec(input longint c[3], output longint r[3]);
		logic [71:0] sq;
		logic [36:0] len;
		longint m;
		logic [63:0] q;
		sq = '0;
		for (int i = 0; i < 3; i++) begin
			m = c[i] < 0 ? -c[i] : c[i];
			sq += 72'(m) * 72'(m);
		end
		len = isqrt(sq);
		for (int i = 0; i < 3; i++) begin
			m = c[i] < 0 ? -c[i] : c[i];
			if (len == 37'd0)
				r[i] = 0;
			else begin
				q = (64'(m) << UNIT_SHIFT) / 64'(len);
				r[i] = c[i] < 0 ? -longint'(q) : longint'(q);
			end
		end
	endfunction

	function automatic logic signed [23:0] sat24(longint v);
		if (v > 8388607)
			return 24'sd8388607;
		if (v < -8388608)
			return -24'sd8388608;
		return v[23:0];
	endfunction

	function automatic void predict_item(logic [1:0] act, logic [11:0] ia, logic [11:0] ib,
		logic [11:0] ic, logic signed [15:0] px, logic signed [15:0] py,
		logic signed [15:0] pz);
		longint d1[3], d2[3], n[3], u[3], s[3], r[3];
		int idx[3];
		case (act)
			ACT_LOAD: begin
				pos_mem[ia][0] = px;
				pos_mem[ia][1] = py;
				pos_mem[ia][2] = pz;
			end
			ACT_TRI: begin
				for (int i = 0; i < 3; i++) begin
					d1[i] = longint'(pos_mem[ib][i]) - longint'(pos_mem[ia][i]);
					d2[i] = longint'(pos_mem[ic][i]) - longint'(pos_mem[ia][i]);
				end
				n[0] = d1[1] * d2[2] - d1[2] * d2[1];
				n[1] = d1[2] * d2[0] - d1[0] * d2[2];
				n[2] = d1[0] * d2[1] - d1[1] * d2[0];
				unit_vec(n, u);
				idx[0] = int'(ia);
				idx[1] = int'(ib);
				idx[2] = int'(ic);
				for (int k = 0; k < 3; k++)
					for (int i = 0; i < 3; i++)
						sum_mem[idx[k]][i] = sat24(longint'(sum_mem[idx[k]][i]) + u[i]);
			end
			ACT_READ: begin
				for (int i = 0; i < 3; i++)
					s[i] = longint'(sum_mem[ia][i]);
				if (norm_mode)
					unit_vec(s, r);
				else
					r = s;
				sb.note_read(r[0][23:0], r[1][23:0], r[2][23:0]);
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(logic [1:0] act, logic [11:0] ia, logic [11:0] ib,
		logic [11:0] ic, logic signed [15:0] px, logic signed [15:0] py,
		logic signed [15:0] pz);
		int gap;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.action <= act;
		item.index_a <= ia;
		item.index_b <= ib;
		item.index_c <= ic;
		item.pos_x <= px;
		item.pos_y <= py;
		item.pos_z <= pz;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		if (act == ACT_LOAD && !loaded[ia]) begin
			loaded[ia] = 1'b1;
			loaded_list = {loaded_list, int'(ia)};
		end
		predict_item(act, ia, ib, ic, px, py, pz);
	endtask

	task automatic drain();
		item.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_mode(bit m);
		cfg.valid <= 1'b1;
		cfg.normalize_readout <= m;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		norm_mode = m;
	endtask

	function automatic logic [11:0] rnd12();
		return 12'($urandom());
	endfunction

	function automatic logic signed [15:0] rnd16();
		return 16'($urandom());
	endfunction

	function automatic logic [11:0] pick_loaded();
		return 12'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
	endfunction

	function automatic logic [11:0] pick_any();
		if ($urandom_range(0, 3) == 0)
			return rnd12();
		return 12'($urandom_range(0, 31));
	endfunction

	function automatic logic signed [15:0] pick_pos();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			1: return rnd16();
			default: return $signed(16'($urandom_range(0, 200))) - 16'sd100;
		endcase
	endfunction

	task automatic random_item();
		int sel;
		logic [11:0] ib;
		sel = $urandom_range(0, 19);
		if (sel < 5 || loaded_list.size() < 3)
			send_item(ACT_LOAD, pick_any(), rnd12(), rnd12(), pick_pos(), pick_pos(),
				pick_pos());
		else if (sel < 13) begin
			ib = pick_loaded();
			send_item(ACT_TRI, pick_loaded(), ib, $urandom_range(0, 7) == 0 ? ib : pick_loaded(),
				rnd16(), rnd16(), rnd16());
		end else if (sel < 19)
			send_item(ACT_READ, $urandom_range(0, 5) == 0 ? pick_any() : pick_loaded(),
				rnd12(), rnd12(), rnd16(), rnd16(), rnd16());
		else
			send_item(ACT_NONE, rnd12(), rnd12(), rnd12(), pick_pos(), pick_pos(), pick_pos());
	endtask

	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			sb.check_result(result.normal_x, result.normal_y, result.normal_z);
	end

	initial begin
		int gap;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx)
				result.ready <= 1'b0;
			else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 6);
				result.ready <= 1'b0;
				repeat (gap - 1) @(posedge clk);
			end else
				result.ready <= 1'b1;
		end
	end

	initial begin
		sb = new();
		arst_n <= 1'b0;
		for (int i = 0; i < VTX_DEPTH; i++)
			for (int j = 0; j < 3; j++) begin
				pos_mem[i][j] = '0;
				sum_mem[i][j] = '0;
			end
		item.valid = 1'b0;
		item.action = ACT_NONE;
		item.index_a = '0;
		item.index_b = '0;
		item.index_c = '0;
		item.pos_x = '0;
		item.pos_y = '0;
		item.pos_z = '0;
		cfg.valid = 1'b0;
		cfg.normalize_readout = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b0);

		// directed: extremes, degenerate triangles, the last index, unused code
		send_item(ACT_READ, 12'd4095, 12'd0, 12'd0, 16'sd0, 16'sd0, 16'sd0);
		send_item(ACT_LOAD, 12'd0, 12'hfff, 12'hfff, 16'sh8000, 16'sh8000, 16'sh8000);
		send_item(ACT_LOAD, 12'd1, 12'd0, 12'd0, 16'sh7fff, 16'sh8000, 16'sh7fff);
		send_item(ACT_LOAD, 12'd2, 12'd0, 12'd0, 16'sh8000, 16'sh7fff, 16'sh7fff);
		send_item(ACT_LOAD, 12'd4095, 12'd0, 12'd0, 16'sh7fff, 16'sh7fff, 16'sh8000);
		send_item(ACT_TRI, 12'd0, 12'd1, 12'd2, 16'shffff, 16'shffff, 16'shffff);
		send_item(ACT_TRI, 12'd4095, 12'd1, 12'd2, 16'sd0, 16'sd0, 16'sd0);
		send_item(ACT_TRI, 12'd0, 12'd0, 12'd1, 16'sd0, 16'sd0, 16'sd0);
		send_item(ACT_READ, 12'd0, 12'hfff, 12'hfff, 16'shffff, 16'shffff, 16'shffff);
		send_item(ACT_READ, 12'd4095, 12'd0, 12'd0, 16'sd0, 16'sd0, 16'sd0);
		send_item(ACT_NONE, 12'hfff, 12'hfff, 12'hfff, 16'shffff, 16'shffff, 16'shffff);
		send_item(ACT_LOAD, 12'd10, 12'd0, 12'd0, 16'sd0, 16'sd0, 16'sd0);
		send_item(ACT_LOAD, 12'd11, 12'd0, 12'd0, 16'sd1, 16'sd0, 16'sd0);
		send_item(ACT_LOAD, 12'd12, 12'd0, 12'd0, 16'sd0, 16'sd1, 16'sd0);
		for (int i = 0; i < 6; i++)
			send_item(ACT_TRI, 12'd10, 12'd11, 12'd12, 16'sd0, 16'sd0, 16'sd0);
		send_item(ACT_READ, 12'd10, 12'd0, 12'd0, 16'sd0, 16'sd0, 16'sd0);
		drain();
		write_mode(1'b1);
		send_item(ACT_READ, 12'd10, 12'd0, 12'd0, 16'sd0, 16'sd0, 16'sd0);
		send_item(ACT_READ, 12'd0, 12'd0, 12'd0, 16'sd0, 16'sd0, 16'sd0);
		send_item(ACT_READ, 12'd30, 12'd0, 12'd0, 16'sd0, 16'sd0, 16'sd0);
		drain();

		// saturation of one sum under many equal triangles
		write_mode(1'b0);
		for (int i = 0; i < 520; i++)
			send_item(ACT_TRI, 12'd11, 12'd12, 12'd10, 16'sd0, 16'sd0, 16'sd0);
		send_item(ACT_READ, 12'd11, 12'd0, 12'd0, 16'sd0, 16'sd0, 16'sd0);

		// long receiver hold while items keep coming
		hold_rx = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_rx = 1'b0;
			end
			begin
				for (int i = 0; i < 12; i++)
					send_item(ACT_READ, pick_loaded(), 12'd0, 12'd0, 16'sd0, 16'sd0,
						16'sd0);
				for (int i = 0; i < 6; i++)
					random_item();
			end
		join
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			write_mode(phase[0]);
			for (int i = 0; i < 220; i++)
				random_item();
			drain();
		end
		rx_idle_on = 1'b0;
		tx_idle_on = 1'b0;
		write_mode(1'b1);
		for (int i = 0; i < 100; i++)
			random_item();
		drain();

		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

### filelist.f
rtl/core/vna_pkg.sv
rtl/core/vna_if.sv
rtl/core/vna_ram.sv
rtl/core/vna_mul.sv
rtl/core/vna_sqrt.sv
rtl/core/vna_div.sv
rtl/core/vertex_normal_accumulator_unit.sv
tb/sv/tb.sv
